>>> rtl/dadw_pkg.sv
// dadw_pkg: shared types, constants and small tables for the date advance unit.
// Used by dadw_ctrl, dadw_dpath and date_add_days_weekday_unit; depends on nothing.
package dadw_pkg;

    // Input transfer payload
    typedef struct packed {
        logic [4:0]  start_day;
        logic [3:0]  start_month;
        logic [13:0] start_year;
        logic [15:0] days_to_add;
    } t_date_in;

    // Result transfer payload
    typedef struct packed {
        logic [4:0]  new_day;
        logic [3:0]  new_month;
        logic [13:0] new_year;
        logic [2:0]  weekday;
        logic        bad_date;
    } t_date_out;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV,
        S_REM,
        S_CHECK,
        S_STEP,
        S_ZSUM,
        S_ZMOD,
        S_OUT
    } t_state;

    // Controller to datapath commands
    typedef struct packed {
        logic load;
        logic div;
        logic rem;
        logic check;
        logic step;
        logic zsum;
        logic zmod;
        logic emit;
    } t_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic bad;
        logic left_zero;
    } t_stat;

    localparam logic [13:0] YEAR_MAX   = 14'd16383;
    localparam logic [12:0] DIV100_MUL = 13'd5243;   // 2^19 / 100, rounded up
    localparam logic [13:0] MOD7_MUL   = 14'd9363;   // 2^16 / 7, rounded up
    localparam logic [3:0]  MONTH_JAN  = 4'd1;
    localparam logic [3:0]  MONTH_FEB  = 4'd2;
    localparam logic [3:0]  MONTH_MAR  = 4'd3;
    localparam logic [3:0]  MONTH_DEC  = 4'd12;
    localparam logic [6:0]  YLO_LAST   = 7'd99;

    // Days in month m; only meaningful for m in 1..12
    function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
        logic [4:0] n;
        case (m)
            4'd2:    n = leap ? 5'd29 : 5'd28;
            4'd4:    n = 5'd30;
            4'd6:    n = 5'd30;
            4'd9:    n = 5'd30;
            4'd11:   n = 5'd30;
            default: n = 5'd31;
        endcase
        return n;
    endfunction

    // floor(13 * (mm + 1) / 5) with Jan/Feb taken as months 13/14
    function automatic logic [5:0] zel_shift(input logic [3:0] m);
        logic [5:0] v;
        case (m)
            4'd1:    v = 6'd36;
            4'd2:    v = 6'd39;
            4'd3:    v = 6'd10;
            4'd4:    v = 6'd13;
            4'd5:    v = 6'd15;
            4'd6:    v = 6'd18;
            4'd7:    v = 6'd20;
            4'd8:    v = 6'd23;
            4'd9:    v = 6'd26;
            4'd10:   v = 6'd28;
            4'd11:   v = 6'd31;
            4'd12:   v = 6'd33;
            default: v = 6'd0;
        endcase
        return v;
    endfunction

endpackage

>>> rtl/dadw_ctrl.sv
// dadw_ctrl: sequencer for the date advance unit.
// Depends on dadw_pkg; drives dadw_dpath through t_cmd and reads t_stat.
module dadw_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            start,
    input  dadw_pkg::t_stat i_stat,
    output dadw_pkg::t_cmd  o_cmd,
    output logic            busy,
    output logic            o_done
);

    dadw_pkg::t_state r_state, n_state;
    logic             r_valid, n_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= dadw_pkg::S_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
        end
    end

    always_comb begin
        n_state = r_state;
        n_valid = 1'b0;
        o_cmd   = '0;
        case (r_state)
            dadw_pkg::S_IDLE: begin
                if (start) begin
                    o_cmd.load = 1'b1;
                    n_state    = dadw_pkg::S_DIV;
                end
            end
            dadw_pkg::S_DIV: begin
                o_cmd.div = 1'b1;
                n_state   = dadw_pkg::S_REM;
            end
            dadw_pkg::S_REM: begin
                o_cmd.rem = 1'b1;
                n_state   = dadw_pkg::S_CHECK;
            end
            dadw_pkg::S_CHECK: begin
                o_cmd.check = 1'b1;
                n_state     = i_stat.bad ? dadw_pkg::S_OUT : dadw_pkg::S_STEP;
            end
            dadw_pkg::S_STEP: begin
                if (i_stat.left_zero) begin
                    n_state = dadw_pkg::S_ZSUM;
                end else begin
                    o_cmd.step = 1'b1;
                end
            end
            dadw_pkg::S_ZSUM: begin
                o_cmd.zsum = 1'b1;
                n_state    = dadw_pkg::S_ZMOD;
            end
            dadw_pkg::S_ZMOD: begin
                o_cmd.zmod = 1'b1;
                n_state    = dadw_pkg::S_OUT;
            end
            dadw_pkg::S_OUT: begin
                o_cmd.emit = 1'b1;
                n_valid    = 1'b1;
                n_state    = dadw_pkg::S_IDLE;
            end
            default: begin
                n_state = dadw_pkg::S_IDLE;
            end
        endcase
    end

    assign busy   = (r_state != dadw_pkg::S_IDLE);
    assign o_done = r_valid;

endmodule

>>> rtl/dadw_dpath.sv
// dadw_dpath: date registers, month stepper, year split and weekday arithmetic.
// Depends on dadw_pkg; sequenced by dadw_ctrl through t_cmd.
module dadw_dpath (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  dadw_pkg::t_cmd     i_cmd,
    input  dadw_pkg::t_date_in i_item,
    output dadw_pkg::t_stat    o_stat,
    output dadw_pkg::t_date_out o_res
);

    logic [4:0]  r_day;
    logic [3:0]  r_month;
    logic [13:0] r_year;
    logic [15:0] r_left;
    logic [7:0]  r_yhi;     // year / 100
    logic [6:0]  r_ylo;     // year % 100
    logic        r_bad;
    logic [10:0] r_sum;
    logic [7:0]  r_q;
    dadw_pkg::t_date_out r_res;

    logic        w_leap;
    logic [4:0]  w_len;
    logic [4:0]  w_rest;
    logic [26:0] w_div_prod;
    logic [13:0] w_hund;
    logic        w_early;
    logic [7:0]  w_j;
    logic [6:0]  w_k;
    logic [10:0] w_sum;
    logic [24:0] w_mod_prod;
    logic [10:0] w_rem7;

    // y%4 follows from y%100; y%400 from (y/100)%4
    assign w_leap = (r_ylo[1:0] == 2'd0) && ((r_ylo != 7'd0) || (r_yhi[1:0] == 2'd0));
    assign w_len  = dadw_pkg::month_len(r_month, w_leap);
    assign w_rest = w_len - r_day;

    assign o_stat.bad = (r_month == 4'd0) || (r_month > dadw_pkg::MONTH_DEC) ||
                        (r_day == 5'd0) || (r_day > w_len);
    assign o_stat.left_zero = (r_left == 16'd0);

    assign w_div_prod = 27'(r_year) * 27'(dadw_pkg::DIV100_MUL);
    assign w_hund     = 14'(r_yhi) * 14'd100;

    // Zeller on year + 400, Jan/Feb belong to the year before
    assign w_early = (r_month < dadw_pkg::MONTH_MAR);
    always_comb begin
        w_k = r_ylo;
        w_j = r_yhi + 8'd4;
        if (w_early) begin
            if (r_ylo == 7'd0) begin
                w_k = dadw_pkg::YLO_LAST;
                w_j = r_yhi + 8'd3;
            end else begin
                w_k = r_ylo - 7'd1;
            end
        end
    end

    assign w_sum = 11'(r_day) + 11'(dadw_pkg::zel_shift(r_month)) + 11'(w_k) +
                   11'(w_k >> 2) + 11'(w_j >> 2) + 11'(w_j) * 11'd5 + 11'd6;

    assign w_mod_prod = 25'(r_sum) * 25'(dadw_pkg::MOD7_MUL);
    assign w_rem7     = r_sum - 11'(r_q) * 11'd7;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_day   <= i_item.start_day;
            r_month <= i_item.start_month;
            r_year  <= i_item.start_year;
            r_left  <= i_item.days_to_add;
        end
        if (i_cmd.div) begin
            r_yhi <= w_div_prod[26:19];
        end
        if (i_cmd.rem) begin
            r_ylo <= 7'(r_year - w_hund);
        end
        if (i_cmd.check) begin
            r_bad <= o_stat.bad;
        end
        if (i_cmd.step) begin
            if (r_left > 16'(w_rest)) begin
                r_left <= r_left - 16'(w_rest) - 16'd1;
                r_day  <= 5'd1;
                if (r_month == dadw_pkg::MONTH_DEC) begin
                    r_month <= dadw_pkg::MONTH_JAN;
                    if (r_year == dadw_pkg::YEAR_MAX) begin
                        r_year <= 14'd0;
                        r_yhi  <= 8'd0;
                        r_ylo  <= 7'd0;
                    end else begin
                        r_year <= r_year + 14'd1;
                        if (r_ylo == dadw_pkg::YLO_LAST) begin
                            r_ylo <= 7'd0;
                            r_yhi <= r_yhi + 8'd1;
                        end else begin
                            r_ylo <= r_ylo + 7'd1;
                        end
                    end
                end else begin
                    r_month <= r_month + 4'd1;
                end
            end else begin
                r_day  <= r_day + 5'(r_left);
                r_left <= 16'd0;
            end
        end
        if (i_cmd.zsum) begin
            r_sum <= w_sum;
        end
        if (i_cmd.zmod) begin
            r_q <= w_mod_prod[23:16];
        end
        if (i_cmd.emit) begin
            r_res.new_day   <= r_day;
            r_res.new_month <= r_month;
            r_res.new_year  <= r_year;
            r_res.weekday   <= r_bad ? 3'd0 : w_rem7[2:0];
            r_res.bad_date  <= r_bad;
        end
    end

    assign o_res = r_res;

    a_step_month: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.step |-> (r_month != 4'd0) && (r_month <= dadw_pkg::MONTH_DEC))
        else $error("month out of range while stepping");

    a_step_day: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.step |-> (r_day != 5'd0) && (r_day <= w_len))
        else $error("day beyond month length while stepping");

    a_ylo_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.step || i_cmd.zsum) |-> (r_ylo <= dadw_pkg::YLO_LAST))
        else $error("year-in-century out of range");

    a_bad_weekday: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.emit && r_bad) |=> (o_res.weekday == 3'd0) && o_res.bad_date)
        else $error("invalid start must give weekday zero");

endmodule

>>> rtl/date_add_days_weekday_unit.sv
// date_add_days_weekday_unit: top level of the Gregorian date advance unit.
// Depends on dadw_pkg, dadw_ctrl and dadw_dpath.
//
//  channel   ports                         transfer when
//  -------   ---------------------------   ------------------------------
//  item in   start, busy, i_item           start high and busy low
//  result    o_done, o_res                 o_done high (one cycle, no stall)
//
// The stepper retires one month per cycle, one step for each month boundary
// crossed (up to about 2150 for 65535 days), plus one when the count ends
// inside a month. An invalid start date goes from the check straight to the
// result, skipping the stepper and the weekday arithmetic.
// The start year is split into century and year-in-century once per item,
// then both are kept up to date incrementally for the leap rule and weekday.
// busy drops in the cycle o_done rises, so the next item can transfer then.
// Synchronous active-low reset returns the sequencer to idle, no result pending.
module date_add_days_weekday_unit (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    input  dadw_pkg::t_date_in   i_item,
    output logic                 busy,
    output logic                 o_done,
    output dadw_pkg::t_date_out  o_res
);

    dadw_pkg::t_cmd  w_cmd;
    dadw_pkg::t_stat w_stat;

    // Sequencer: accept, split year, check, step months, weekday, emit; a bad date goes from check to emit
    dadw_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_stat  (w_stat),
        .o_cmd   (w_cmd),
        .busy    (busy),
        .o_done  (o_done)
    );

    // Date registers and arithmetic; result register holds until next emit
    dadw_dpath u_dpath (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_cmd),
        .i_item  (i_item),
        .o_stat  (w_stat),
        .o_res   (o_res)
    );

endmodule
